// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication violated");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// ===== src/cap_pkg.sv =====
// Shared constants and types for the cascaded attitude controller.
`timescale 1ns / 1ps
`default_nettype none
package cap_pkg;

  localparam int AXES        = 3;
  localparam int AXIS_SLOTS  = 3;

  localparam int SIG_W       = 16;
  localparam int GAIN_W      = 16;
  localparam int DT_W        = 16;
  localparam int DRIVE_W     = 13;

  localparam int IN_TDATA_W  = 7 * SIG_W;
  localparam int DRIVES_W    = AXIS_SLOTS * DRIVE_W;
  localparam int OUT_TDATA_W = ((DRIVES_W + 7) / 8) * 8;

  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 5;
  localparam int REG_LSB     = 3;
  localparam int NUM_REGS    = 4;
  localparam int REG_IDX_W   = CFG_ADDR_W - REG_LSB;
  localparam int REG_W       = 48;

  localparam logic [REG_IDX_W-1:0] REG_ANGLE_P = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_RATE_P  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RATE_I  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_RATE_D  = 2'd3;

  localparam int MUL_A_W     = 41;
  localparam int MUL_B_W     = 16;
  localparam int MUL_P_W     = MUL_A_W + 1 + MUL_B_W;
  localparam int MUL_CNT_W   = $clog2(MUL_B_W);

  localparam int FRAC_SHIFT  = 8;
  localparam int INC_SHIFT   = 24;
  localparam int MAG_W       = 32;
  localparam int DIV_W       = MAG_W + FRAC_SHIFT;
  localparam int DIV_CNT_W   = $clog2(DIV_W);

  localparam int DIFF_W      = SIG_W + 1;
  localparam int SP_W        = 24;
  localparam int ERR_W       = SP_W + 1;
  localparam int P_W         = 33;
  localparam int INC_W       = 33;
  localparam int INT_SUM_W   = INC_W + 1;
  localparam int INT_W       = 10;
  localparam int D_W         = DIV_W + 1;
  localparam int ACC_W       = 43;

  localparam int I_LIMIT     = 410;
  localparam int OUT_LIMIT   = 2048;

  typedef struct packed {
    logic [GAIN_W-1:0] kpa;
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } axis_gains_t;

  typedef struct packed {
    logic start;
    logic ack;
  } lane_cmd_t;

endpackage
`default_nettype wire

// ===== src/cap_serial_mul.sv =====
// Shift-add multiplier: signed multiplicand times unsigned 16-bit multiplier, one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module cap_serial_mul (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start_i,
  input  logic signed [cap_pkg::MUL_A_W-1:0]   a_i,
  input  logic        [cap_pkg::MUL_B_W-1:0]   b_i,
  output logic                                 done_o,
  output logic signed [cap_pkg::MUL_P_W-1:0]   prod_o
);
  import cap_pkg::*;

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [MUL_CNT_W-1:0]      cnt_r, cnt_nxt;
  logic signed [MUL_A_W-1:0] a_r, a_nxt;
  logic signed [MUL_A_W:0]   hi_r, hi_nxt;
  logic [MUL_B_W-1:0]        lo_r, lo_nxt;
  logic signed [MUL_A_W:0]   addend;
  logic signed [MUL_A_W:0]   sum;

  always_comb begin
    addend   = lo_r[0] ? (MUL_A_W+1)'(a_r) : '0;
    sum      = hi_r + addend;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    if (start_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = MUL_CNT_W'(MUL_B_W - 1);
      a_nxt    = a_i;
      hi_nxt   = '0;
      lo_nxt   = b_i;
    end else if (busy_r) begin
      hi_nxt  = {sum[MUL_A_W], sum[MUL_A_W:1]};
      lo_nxt  = {sum[0], lo_r[MUL_B_W-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r  <= a_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign done_o = done_r;
  assign prod_o = {hi_r, lo_r};

endmodule
`default_nettype wire

// ===== src/cap_serial_div.sv =====
// Restoring divider: magnitude by unsigned time step, one quotient bit a cycle, sign applied at the end.
`timescale 1ns / 1ps
`default_nettype none
module cap_serial_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start_i,
  input  logic [cap_pkg::DIV_W-1:0]         mag_i,
  input  logic                              neg_i,
  input  logic [cap_pkg::DT_W-1:0]          den_i,
  output logic                              busy_o,
  output logic signed [cap_pkg::D_W-1:0]    quo_o
);
  import cap_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     q_r, q_nxt;
  logic [DT_W-1:0]      rem_r, rem_nxt;
  logic [DT_W-1:0]      den_r, den_nxt;
  logic                 neg_r, neg_nxt;
  logic [DT_W:0]        shifted;
  logic [DT_W+1:0]      trial;
  logic                 fits;

  always_comb begin
    shifted  = {rem_r, q_r[DIV_W-1]};
    trial    = {1'b0, shifted} - {2'b00, den_r};
    fits     = !trial[DT_W+1];
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (start_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_W - 1);
      q_nxt    = mag_i;
      rem_nxt  = '0;
      den_nxt  = den_i;
      neg_nxt  = neg_i;
    end else if (busy_r) begin
      rem_nxt = fits ? trial[DT_W-1:0] : shifted[DT_W-1:0];
      q_nxt   = {q_r[DIV_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign busy_o = busy_r;
  assign quo_o  = neg_r ? -D_W'(q_r) : D_W'(q_r);

endmodule
`default_nettype wire

// ===== src/cap_axis_lane.sv =====
// One axis: sequencer over the serial multiplier and divider, integrator and previous gyro.
`timescale 1ns / 1ps
`default_nettype none
module cap_axis_lane (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cap_pkg::lane_cmd_t                  cmd,
  input  cap_pkg::axis_gains_t                gains,
  input  logic signed [cap_pkg::SIG_W-1:0]    ang_i,
  input  logic signed [cap_pkg::SIG_W-1:0]    gyr_i,
  input  logic        [cap_pkg::DT_W-1:0]     dt_i,
  output logic                                done_o,
  output logic signed [cap_pkg::DRIVE_W-1:0]  drive_o
);
  import cap_pkg::*;

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_MD   = 3'd1;
  localparam logic [2:0] L_M1   = 3'd2;
  localparam logic [2:0] L_M2   = 3'd3;
  localparam logic [2:0] L_M3   = 3'd4;
  localparam logic [2:0] L_M4   = 3'd5;
  localparam logic [2:0] L_WD   = 3'd6;
  localparam logic [2:0] L_DONE = 3'd7;

  logic [2:0]                state_r, state_nxt;
  logic signed [SIG_W-1:0]   ang_r, ang_nxt;
  logic signed [SIG_W-1:0]   gyr_r, gyr_nxt;
  logic [DT_W-1:0]           dt_r, dt_nxt;
  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic signed [P_W-1:0]     p_r, p_nxt;
  logic signed [INT_W-1:0]   integ_r, integ_nxt;
  logic signed [SIG_W-1:0]   last_r, last_nxt;
  logic signed [DRIVE_W-1:0] drive_r, drive_nxt;

  logic                      mul_start;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic                      mul_done;
  logic signed [MUL_P_W-1:0] mul_prod;
  logic                      div_start;
  logic [DIV_W-1:0]          div_mag;
  logic                      div_busy;
  logic signed [D_W-1:0]     div_q;

  logic signed [DIFF_W-1:0]    diff;
  logic [MUL_P_W-1:0]          abs_prod;
  logic signed [SP_W-1:0]      sp;
  logic signed [ERR_W-1:0]     err_new;
  logic signed [P_W-1:0]       p_new;
  logic signed [INC_W-1:0]     inc;
  logic signed [INT_SUM_W-1:0] int_sum;
  logic signed [INT_W-1:0]     int_clamped;
  logic signed [INT_W-1:0]     i_term;
  logic signed [D_W-1:0]       d_term;
  logic signed [ACC_W-1:0]     acc;
  logic signed [DRIVE_W-1:0]   acc_clamped;

  cap_serial_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  cap_serial_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .mag_i   (div_mag),
    .neg_i   (mul_prod[MUL_P_W-1]),
    .den_i   (dt_r),
    .busy_o  (div_busy),
    .quo_o   (div_q)
  );

  always_comb begin
    diff     = DIFF_W'(last_r) - DIFF_W'(gyr_i);
    abs_prod = mul_prod[MUL_P_W-1] ? MUL_P_W'(-mul_prod) : MUL_P_W'(mul_prod);
    div_mag  = {abs_prod[MAG_W-1:0], FRAC_SHIFT'(0)};
    sp       = mul_prod[SP_W+FRAC_SHIFT-1:FRAC_SHIFT];
    err_new  = ERR_W'(sp) - ERR_W'(gyr_r);
    p_new    = mul_prod[P_W+FRAC_SHIFT-1:FRAC_SHIFT];
    inc      = mul_prod[INC_W+INC_SHIFT-1:INC_SHIFT];
    int_sum  = INT_SUM_W'(inc) + INT_SUM_W'(integ_r);
    if (int_sum > INT_SUM_W'(I_LIMIT)) begin
      int_clamped = INT_W'(I_LIMIT);
    end else if (int_sum < INT_SUM_W'(-I_LIMIT)) begin
      int_clamped = INT_W'(-I_LIMIT);
    end else begin
      int_clamped = INT_W'(int_sum);
    end
    i_term = (gains.ki != '0) ? integ_r : '0;
    d_term = (dt_r != '0) ? div_q : '0;
    acc    = ACC_W'(p_r) + ACC_W'(i_term) + ACC_W'(d_term);
    if (acc > ACC_W'(OUT_LIMIT)) begin
      acc_clamped = DRIVE_W'(OUT_LIMIT);
    end else if (acc < ACC_W'(-OUT_LIMIT)) begin
      acc_clamped = DRIVE_W'(-OUT_LIMIT);
    end else begin
      acc_clamped = DRIVE_W'(acc);
    end

    state_nxt = state_r;
    ang_nxt   = ang_r;
    gyr_nxt   = gyr_r;
    dt_nxt    = dt_r;
    err_nxt   = err_r;
    p_nxt     = p_r;
    integ_nxt = integ_r;
    last_nxt  = last_r;
    drive_nxt = drive_r;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;

    unique case (state_r)
      L_IDLE: begin
        if (cmd.start) begin
          ang_nxt   = ang_i;
          gyr_nxt   = gyr_i;
          dt_nxt    = dt_i;
          mul_start = 1'b1;
          mul_a     = MUL_A_W'(diff);
          mul_b     = gains.kd;
          state_nxt = L_MD;
        end
      end
      L_MD: begin
        if (mul_done) begin
          div_start = 1'b1;
          mul_start = 1'b1;
          mul_a     = MUL_A_W'(ang_r);
          mul_b     = gains.kpa;
          state_nxt = L_M1;
        end
      end
      L_M1: begin
        if (mul_done) begin
          err_nxt   = err_new;
          mul_start = 1'b1;
          mul_a     = MUL_A_W'(err_new);
          mul_b     = gains.kp;
          state_nxt = L_M2;
        end
      end
      L_M2: begin
        if (mul_done) begin
          p_nxt     = p_new;
          mul_start = 1'b1;
          mul_a     = MUL_A_W'(err_r);
          mul_b     = gains.ki;
          state_nxt = L_M3;
        end
      end
      L_M3: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = $signed(mul_prod[MUL_A_W-1:0]);
          mul_b     = dt_r;
          state_nxt = L_M4;
        end
      end
      L_M4: begin
        if (mul_done) begin
          if (gains.ki != '0) begin
            integ_nxt = int_clamped;
          end
          state_nxt = L_WD;
        end
      end
      L_WD: begin
        if (!div_busy) begin
          drive_nxt = acc_clamped;
          last_nxt  = gyr_r;
          state_nxt = L_DONE;
        end
      end
      L_DONE: begin
        if (cmd.ack) begin
          state_nxt = L_IDLE;
        end
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      integ_r <= '0;
      last_r  <= '0;
    end else begin
      state_r <= state_nxt;
      integ_r <= integ_nxt;
      last_r  <= last_nxt;
    end
    ang_r   <= ang_nxt;
    gyr_r   <= gyr_nxt;
    dt_r    <= dt_nxt;
    err_r   <= err_nxt;
    p_r     <= p_nxt;
    drive_r <= drive_nxt;
  end

  assign done_o  = (state_r == L_DONE);
  assign drive_o = drive_r;

endmodule
`default_nettype wire

// ===== src/cascaded_attitude_pid.sv =====
// Top level: gain registers, axis lanes, input handshake and output register.
//
// Channel  Role    Handshake                 Contents
// in_      slave   in_tvalid / in_tready     three angle errors, three gyro rates, time step
// out_     master  out_tvalid / out_tready   roll, pitch and yaw drive
// cfg_     APB     psel, penable, pready     four 48-bit gain registers at byte 8*i
//
// The three axes run in parallel lanes, each paced by five 16-step shift-add
// multiplications, with the 40-step divider running alongside the last four. Reset clears
// the gains, integrators and previous gyro. A result stalled in the output register does
// not block the next item, whose result waits in the lanes until the register frees.
`timescale 1ns / 1ps
`default_nettype none
module cascaded_attitude_pid (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // angle_err_roll, angle_err_pitch, angle_err_yaw, gyro_roll, gyro_pitch, gyro_yaw,
  // time_step, 16 bits each
  input  logic [cap_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // drive_roll, drive_pitch, drive_yaw, 13 bits each, one zero pad bit
  output logic [cap_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [cap_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [cap_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [cap_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);
  import cap_pkg::*;

  logic [REG_W-1:0]    gain_regs_r [NUM_REGS];
  logic [REG_W-1:0]    gain_regs_nxt [NUM_REGS];
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  logic                busy_r, busy_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DRIVES_W-1:0] out_data_r, out_data_nxt;

  logic                      accept;
  logic                      handoff;
  lane_cmd_t                 cmd;
  logic [AXIS_SLOTS-1:0]     lane_done;
  logic [DRIVES_W-1:0]       lane_drives;
  axis_gains_t               gains [AXIS_SLOTS];

  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:REG_LSB];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = CFG_DATA_W'(gain_regs_r[reg_idx]);

  always_comb begin
    for (int r = 0; r < NUM_REGS; r++) begin
      gain_regs_nxt[r] = gain_regs_r[r];
    end
    if (cfg_wr) begin
      gain_regs_nxt[reg_idx] = cfg_pwdata[REG_W-1:0];
    end
  end

  assign accept    = in_tvalid & in_tready;
  assign in_tready = !busy_r;
  assign handoff   = busy_r & (&lane_done) & (!out_valid_r | out_tready);
  assign cmd.start = accept;
  assign cmd.ack   = handoff;

  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end
    if (handoff) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      out_data_nxt  = lane_drives;
    end else if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < NUM_REGS; r++) begin
        gain_regs_r[r] <= '0;
      end
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      for (int r = 0; r < NUM_REGS; r++) begin
        gain_regs_r[r] <= gain_regs_nxt[r];
      end
    end
    out_data_r <= out_data_nxt;
  end

  for (genvar a = 0; a < AXIS_SLOTS; a++) begin : g_axis
    assign gains[a].kpa = gain_regs_r[REG_ANGLE_P][GAIN_W*a +: GAIN_W];
    assign gains[a].kp  = gain_regs_r[REG_RATE_P][GAIN_W*a +: GAIN_W];
    assign gains[a].ki  = gain_regs_r[REG_RATE_I][GAIN_W*a +: GAIN_W];
    assign gains[a].kd  = gain_regs_r[REG_RATE_D][GAIN_W*a +: GAIN_W];

    if (a < AXES) begin : g_lane
      cap_axis_lane u_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .gains   (gains[a]),
        .ang_i   (in_tdata[SIG_W*a +: SIG_W]),
        .gyr_i   (in_tdata[SIG_W*(AXIS_SLOTS+a) +: SIG_W]),
        .dt_i    (in_tdata[SIG_W*2*AXIS_SLOTS +: DT_W]),
        .done_o  (lane_done[a]),
        .drive_o (lane_drives[DRIVE_W*a +: DRIVE_W])
      );
    end else begin : g_off
      assign lane_done[a]                      = 1'b1;
      assign lane_drives[DRIVE_W*a +: DRIVE_W] = '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

endmodule
`default_nettype wire

// ===== src/cap_checker.sv =====
// Port-level checker for the attitude controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cap_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [cap_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import cap_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `ASSERT_IMP(a_roll_range, clk, rst_n, out_tvalid, ($signed(out_tdata[DRIVE_W-1:0]) <= 13'sd2048) && ($signed(out_tdata[DRIVE_W-1:0]) >= -13'sd2048))
  `ASSERT_IMP(a_yaw_range, clk, rst_n, out_tvalid, ($signed(out_tdata[3*DRIVE_W-1:2*DRIVE_W]) <= 13'sd2048) && ($signed(out_tdata[3*DRIVE_W-1:2*DRIVE_W]) >= -13'sd2048))

endmodule

bind cascaded_attitude_pid cap_checker u_cap_checker (.*);
`default_nettype wire
